// ===== design/isqrr_pkg.sv =====
// ----------------------------------------------------------------------------
// Rounded integer square root: shared definitions
// Default widths for the pipelined digit-by-digit square root.
// ----------------------------------------------------------------------------
package isqrr_pkg;

	localparam int DEF_INPUT_BITS = 32;

	// Number of root digits resolved for a radicand of the given width.
	function automatic int num_steps(input int input_bits);
		return (input_bits + 1) / 2;
	endfunction

	// Bit position of the probe at the first step: the highest even position.
	function automatic int top_probe_pos(input int input_bits);
		return ((input_bits - 1) / 2) * 2;
	endfunction

endpackage

// ===== design/isqrr_step.sv =====
// ----------------------------------------------------------------------------
// Rounded integer square root: one digit stage
// Resolves one root bit with a compare and subtract, then registers the
// remainder and partial root for the next stage.
// ----------------------------------------------------------------------------
module isqrr_step #(
	parameter int W         = isqrr_pkg::DEF_INPUT_BITS,
	parameter int PROBE_POS = 0
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] rem_in,
	input  logic [W:0]   acc_in,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] rem_out,
	output logic [W:0]   acc_out
);

	localparam logic [W:0] PROBE = {{W{1'b0}}, 1'b1} << PROBE_POS;

	logic         valid_s1;
	logic [W-1:0] rem_s1;
	logic [W:0]   acc_s1;
	logic [W:0]   trial;
	logic [W+1:0] acc_sum;
	logic         take;
	logic [W-1:0] rem_next;
	logic [W:0]   acc_next;

	always_comb begin
		trial    = acc_in + PROBE;
		take     = {1'b0, rem_in} >= trial;
		acc_sum  = {1'b0, trial} + {1'b0, PROBE};
		rem_next = take ? (rem_in - trial[W-1:0]) : rem_in;
		acc_next = take ? acc_sum[W+1:1] : (acc_in >> 1);
	end

	// The stage may load whenever its register is empty or being emptied.
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rem_s1 <= rem_next;
			acc_s1 <= acc_next;
		end
	end

	assign out_valid = valid_s1;
	assign rem_out   = rem_s1;
	assign acc_out   = acc_s1;

endmodule

// ===== design/isqrr_round.sv =====
// ----------------------------------------------------------------------------
// Rounded integer square root: rounding and output stage
// Rounds the truncated root up when the remainder exceeds it and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module isqrr_round #(
	parameter int W         = isqrr_pkg::DEF_INPUT_BITS,
	parameter int ROOT_BITS = isqrr_pkg::DEF_INPUT_BITS / 2 + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [W-1:0]         rem_in,
	input  logic [W:0]           acc_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ROOT_BITS-1:0] root
);

	logic                 valid_s1;
	logic [ROOT_BITS-1:0] root_s1;
	logic                 round_up;
	logic [W:0]           rounded;

	always_comb begin
		round_up = {1'b0, rem_in} > acc_in;
		rounded  = acc_in + {{W{1'b0}}, round_up};
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			root_s1 <= rounded[ROOT_BITS-1:0];
		end
	end

	assign out_valid = valid_s1;
	assign root      = root_s1;

endmodule

// ===== design/integer_square_root_rounded.sv =====
// ----------------------------------------------------------------------------
// Rounded integer square root
// Fully pipelined digit-by-digit square root, rounded to nearest.
// ----------------------------------------------------------------------------
// Each radicand beat passes through one register stage per root bit
// ((INPUT_BITS+1)/2 stages, sixteen at the default width), each doing one
// compare and subtract, and then through a rounding stage that is also the
// output register. That makes (INPUT_BITS+1)/2 + 1 register stages in all
// (seventeen by default). root_valid rises once the beat has been registered
// by every digit stage and then by the rounding stage. A new radicand can be
// taken in every cycle, so the sustained rate is one result per cycle while
// root_ready stays high. When the output is stalled, the stages fill up and
// radicand_ready falls once every stage holds a beat. No state is kept
// between beats.
module integer_square_root_rounded #(
	parameter int INPUT_BITS = isqrr_pkg::DEF_INPUT_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    radicand_valid,
	output logic                    radicand_ready,
	input  logic [INPUT_BITS-1:0]   radicand,
	output logic                    root_valid,
	input  logic                    root_ready,
	output logic [INPUT_BITS/2:0]   root
);

	localparam int ROOT_BITS = INPUT_BITS / 2 + 1;
	localparam int STEPS     = isqrr_pkg::num_steps(INPUT_BITS);
	localparam int TOP_POS   = isqrr_pkg::top_probe_pos(INPUT_BITS);

	logic                  valid_c [STEPS+1];
	logic                  ready_c [STEPS+1];
	logic [INPUT_BITS-1:0] rem_c   [STEPS+1];
	logic [INPUT_BITS:0]   acc_c   [STEPS+1];

	assign valid_c[0]     = radicand_valid;
	assign radicand_ready = ready_c[0];
	assign rem_c[0]       = radicand;
	assign acc_c[0]       = '0;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		isqrr_step #(
			.W         (INPUT_BITS),
			.PROBE_POS (TOP_POS - 2 * i)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_ready  (ready_c[i]),
			.rem_in    (rem_c[i]),
			.acc_in    (acc_c[i]),
			.out_valid (valid_c[i+1]),
			.out_ready (ready_c[i+1]),
			.rem_out   (rem_c[i+1]),
			.acc_out   (acc_c[i+1])
		);
	end

	isqrr_round #(
		.W         (INPUT_BITS),
		.ROOT_BITS (ROOT_BITS)
	) u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_c[STEPS]),
		.in_ready  (ready_c[STEPS]),
		.rem_in    (rem_c[STEPS]),
		.acc_in    (acc_c[STEPS]),
		.out_valid (root_valid),
		.out_ready (root_ready),
		.root      (root)
	);

endmodule

// ===== bench/isqrr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rounded square root checker
// Watches both channels of the square root block, predicts the rounded root
// of every radicand taken and compares it with each root beat delivered.
// ----------------------------------------------------------------------------
module isqrr_checker #(
	parameter int INPUT_BITS = isqrr_pkg::DEF_INPUT_BITS,
	parameter int ROOT_BITS  = INPUT_BITS / 2 + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  radicand_valid,
	input  logic                  radicand_ready,
	input  logic [INPUT_BITS-1:0] radicand,
	input  logic                  root_valid,
	input  logic                  root_ready,
	input  logic [ROOT_BITS-1:0]  root,
	output int                    error_count,
	output int                    pending_roots
);

	logic [ROOT_BITS-1:0] expected_roots[$];
	logic [ROOT_BITS-1:0] wanted_root;

	// Restoring digit-by-digit square root, rounded up when the final
	// remainder is larger than the root.
	function automatic logic [ROOT_BITS-1:0] rounded_sqrt(input logic [INPUT_BITS-1:0] value);
		logic [63:0] remainder;
		logic [63:0] partial;
		logic [63:0] probe;
		logic [63:0] trial;
		remainder = 64'(value);
		partial   = '0;
		probe     = 64'd1 << ((INPUT_BITS - 1) & ~1);
		while (probe != 0) begin
			trial = partial + probe;
			if (remainder >= trial) begin
				remainder = remainder - trial;
				partial   = trial + probe;
			end
			partial = partial >> 1;
			probe   = probe >> 2;
		end
		if (remainder > partial) begin
			partial = partial + 1;
		end
		return partial[ROOT_BITS-1:0];
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (root_valid && root_ready) begin
				if (expected_roots.size() == 0) begin
					$error("root beat with nothing expected: actual %0d", root);
					error_count = error_count + 1;
				end else begin
					wanted_root = expected_roots.pop_front();
					if (root !== wanted_root) begin
						$error("root mismatch: expected %0d, actual %0d", wanted_root, root);
						error_count = error_count + 1;
					end
				end
			end
			if (radicand_valid && radicand_ready) begin
				expected_roots.push_back(rounded_sqrt(radicand));
			end
			pending_roots = expected_roots.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rounded square root testbench
// Drives directed and random radicands into the block, with random stalls on
// both channels in two phases; the checker predicts and compares the roots.
// ----------------------------------------------------------------------------
module tb;

	localparam int INPUT_BITS     = isqrr_pkg::DEF_INPUT_BITS;
	localparam int ROOT_BITS      = INPUT_BITS / 2 + 1;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int PHASE_ITEMS    = 300;

	typedef enum int {
		KIND_ANY,
		KIND_TINY,
		KIND_NEAR_HALF,
		KIND_NEAR_SQUARE,
		KIND_SHIFTED
	} radicand_kind_t;

	logic                  clk;
	logic                  arst_n;
	logic                  radicand_valid;
	logic                  radicand_ready;
	logic [INPUT_BITS-1:0] radicand;
	logic                  root_valid;
	logic                  root_ready;
	logic [ROOT_BITS-1:0]  root;

	int error_count;
	int pending_roots;
	int send_idle_pct;
	int recv_idle_pct;
	int idle_cycles;

	integer_square_root_rounded #(
		.INPUT_BITS(INPUT_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.radicand_valid(radicand_valid),
		.radicand_ready(radicand_ready),
		.radicand      (radicand),
		.root_valid    (root_valid),
		.root_ready    (root_ready),
		.root          (root)
	);

	isqrr_checker #(
		.INPUT_BITS(INPUT_BITS)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.radicand_valid(radicand_valid),
		.radicand_ready(radicand_ready),
		.radicand      (radicand),
		.root_valid    (root_valid),
		.root_ready    (root_ready),
		.root          (root),
		.error_count   (error_count),
		.pending_roots (pending_roots)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			root_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Any beat on either channel counts as progress.
	always @(posedge clk) begin
		if ((radicand_valid && radicand_ready) || (root_valid && root_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat
	// is taken, with valid still high so back-to-back beats need no toggle.
	task automatic drive_radicand(input logic [INPUT_BITS-1:0] value);
		int gaps;
		gaps = 0;
		while ($urandom_range(99) < send_idle_pct) begin
			gaps++;
		end
		if (gaps > 0) begin
			radicand_valid <= 1'b0;
			repeat (gaps) @(negedge clk);
		end
		radicand_valid <= 1'b1;
		radicand       <= value;
		do begin
			@(posedge clk);
		end while (!radicand_ready);
		@(negedge clk);
	endtask

	task automatic wait_for_roots();
		radicand_valid <= 1'b0;
		@(negedge clk);
		while (pending_roots != 0) begin
			@(negedge clk);
		end
	endtask

	// Two of five kinds sit next to the rounding boundary k*k + k or next to an
	// exact square, where an off-by-one root would show.
	function automatic logic [INPUT_BITS-1:0] random_radicand();
		radicand_kind_t kind;
		logic [63:0]    k;
		logic [63:0]    value;
		kind = radicand_kind_t'($urandom_range(KIND_SHIFTED));
		k    = 64'($urandom_range(65535));
		case (kind)
			KIND_ANY:         value = 64'($urandom);
			KIND_TINY:        value = 64'($urandom_range(1023));
			KIND_NEAR_HALF:   value = k * k + k + 64'($urandom_range(2)) - 64'd1;
			KIND_NEAR_SQUARE: value = k * k + 64'($urandom_range(2)) - 64'd1;
			default:          value = 64'($urandom >> $urandom_range(31));
		endcase
		return value[INPUT_BITS-1:0];
	endfunction

	initial begin
		logic [INPUT_BITS-1:0] directed[$];
		logic [63:0]           k;
		arst_n         = 1'b0;
		radicand_valid = 1'b0;
		radicand       = '0;
		root_ready     = 1'b0;
		send_idle_pct  = 0;
		recv_idle_pct  = 0;
		idle_cycles    = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Small values, powers of four, the largest squares and the largest
		// radicand, which needs the seventeenth root bit.
		directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8,
			32'd9, 32'h4000_0000, 32'h8000_0000, 32'h3FFF_FFFF, 32'h5555_5555,
			32'hAAAA_AAAA, 32'hFFFE_0001, 32'hFFFF_0000, 32'hFFFF_0001,
			32'hFFFF_FFFE, 32'hFFFF_FFFF};
		k = 64'($urandom_range(65535));
		directed.push_back(32'(k * k + k));
		directed.push_back(32'(k * k + k + 64'd1));
		foreach (directed[i]) begin
			drive_radicand(directed[i]);
		end
		wait_for_roots();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 7;
					recv_idle_pct = 51;
				end
				1: begin
					send_idle_pct = 51;
					recv_idle_pct = 7;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2) begin
					wait_for_roots();
				end
				drive_radicand(random_radicand());
			end
		end

		wait_for_roots();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0 && pending_roots == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/isqrr_pkg.sv
design/isqrr_step.sv
design/isqrr_round.sv
design/integer_square_root_rounded.sv
bench/isqrr_checker.sv
bench/tb.sv
